// ===== hdl/triangle_barycentric_uv_unit_macros.svh =====
// Assertion macros shared by the barycentric texture-coordinate unit.
`ifndef TRIANGLE_BARYCENTRIC_UV_UNIT_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_UV_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCUV_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bcuv check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCUV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bcuv check failed");

`endif

// ===== hdl/bcuv_pkg.sv =====
// Shared widths, latencies and types of the barycentric texture-coordinate unit.
package bcuv_pkg;

   // Field widths.
   localparam int COORD_W = 20;
   localparam int TEX_W   = 16;
   localparam int OUT_W   = 17;

   // Internal widths of the arithmetic chain.
   localparam int EDGE_W      = COORD_W + 1;
   localparam int PROD_W      = 2 * EDGE_W;
   localparam int DOT_W       = PROD_W + 2;
   localparam int GRAM_W      = 2 * DOT_W;
   localparam int TEXD_W      = TEX_W + 1;
   localparam int NUM_W       = GRAM_W + TEXD_W;
   localparam int QUO_W       = OUT_W;
   localparam int MUL_CHUNK_W = 22;

   // Stage counts of each part.
   localparam int GRAM_LAT = 6;
   localparam int MUL_LAT  = 2;
   localparam int DIV_LAT  = QUO_W + 4;
   localparam int PIPE_LAT = GRAM_LAT + MUL_LAT + 1 + DIV_LAT;

   typedef logic signed [COORD_W-1:0]   coord_type;
   typedef logic [3*COORD_W-1:0]        vertex_type;
   typedef logic [2*TEX_W-1:0]          tex_type;
   typedef logic signed [OUT_W-1:0]     out_type;
   typedef logic signed [GRAM_W-1:0]    gram_type;
   typedef logic signed [NUM_W-1:0]     num_type;
   typedef logic signed [TEXD_W-1:0]    texd_type;

   // Saturation limits of the result.
   localparam out_type OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam out_type OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== hdl/bcuv_if.sv =====
// Request and response channel interfaces of the barycentric texture-coordinate unit.
interface bcuv_req_if import bcuv_pkg::*; ();
   logic       valid;
   logic       ready;
   coord_type  point_x;
   coord_type  point_y;
   coord_type  point_z;
   vertex_type vertex_a;
   vertex_type vertex_b;
   vertex_type vertex_c;
   tex_type    tex_a;
   tex_type    tex_b;
   tex_type    tex_c;

   modport source(output valid, point_x, point_y, point_z, vertex_a, vertex_b, vertex_c,
                  tex_a, tex_b, tex_c, input ready);
   modport sink(input valid, point_x, point_y, point_z, vertex_a, vertex_b, vertex_c,
                tex_a, tex_b, tex_c, output ready);
endinterface

interface bcuv_rsp_if import bcuv_pkg::*; ();
   logic    valid;
   logic    ready;
   out_type out_u;
   out_type out_v;
   logic    degenerate;

   modport source(output valid, out_u, out_v, degenerate, input ready);
   modport sink(input valid, out_u, out_v, degenerate, output ready);
endinterface

// ===== hdl/triangle_barycentric_uv_unit.sv =====
// Top level of the barycentric texture-coordinate interpolation unit.
//
//   channel   direction   contents
//   req_ch    in          hit point, three vertices, three texture coordinates
//   rsp_ch    out         interpolated u and v, degenerate flag
//
// Every item passes from acceptance to its result through the dot products and the
// determinant, the texture weighting multipliers, one sum register, and the divider,
// which produces one quotient bit per stage. One item can enter every cycle unless
// the pipeline holds. Reset clears only the valid bits of the pipeline.
// When a result waits and rsp_ch is not ready, the whole pipeline holds.
`include "triangle_barycentric_uv_unit_macros.svh"

module triangle_barycentric_uv_unit import bcuv_pkg::*; (
   input logic        clock,
   input logic        reset,
   bcuv_req_if.sink   req_ch,
   bcuv_rsp_if.source rsp_ch
);

   logic                en;
   logic [PIPE_LAT-1:0] vld_ff;
   tex_type             ta_ff [GRAM_LAT];
   tex_type             tb_ff [GRAM_LAT];
   tex_type             tc_ff [GRAM_LAT];
   gram_type            den;
   gram_type            nv;
   gram_type            nw;
   gram_type            den_dly_ff [MUL_LAT+1];
   out_type             res [2];
   logic                deg [2];

   // The pipeline advances unless a finished item is waiting.
   assign en           = !vld_ff[PIPE_LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_ch.valid};
      end
   end

   // Texture coordinates follow the item until the determinant is ready.
   always_ff @(posedge clock) begin
      if (en) begin
         ta_ff[0] <= req_ch.tex_a;
         tb_ff[0] <= req_ch.tex_b;
         tc_ff[0] <= req_ch.tex_c;
         for (int k = 1; k < GRAM_LAT; k++) begin
            ta_ff[k] <= ta_ff[k-1];
            tb_ff[k] <= tb_ff[k-1];
            tc_ff[k] <= tc_ff[k-1];
         end
      end
   end

   bcuv_gram u_gram (
      .clock(clock), .en(en),
      .point_x(req_ch.point_x), .point_y(req_ch.point_y), .point_z(req_ch.point_z),
      .vertex_a(req_ch.vertex_a), .vertex_b(req_ch.vertex_b), .vertex_c(req_ch.vertex_c),
      .den(den), .nv(nv), .nw(nw));

   // The determinant travels beside the weighting multipliers and the sum.
   always_ff @(posedge clock) begin
      if (en) begin
         den_dly_ff[0] <= den;
         for (int k = 1; k <= MUL_LAT; k++) begin
            den_dly_ff[k] <= den_dly_ff[k-1];
         end
      end
   end

   // One lane per texture component: TA*den + (TB-TA)*nv + (TC-TA)*nw, then divide.
   for (genvar c = 0; c < 2; c++) begin : g_comp
      texd_type ta;
      texd_type db;
      texd_type dc;
      num_type  pa;
      num_type  pb;
      num_type  pc;
      num_type  num_ff;

      assign ta = {1'b0, ta_ff[GRAM_LAT-1][c*TEX_W +: TEX_W]};
      assign db = {1'b0, tb_ff[GRAM_LAT-1][c*TEX_W +: TEX_W]} - ta;
      assign dc = {1'b0, tc_ff[GRAM_LAT-1][c*TEX_W +: TEX_W]} - ta;

      bcuv_mul #(.AW(GRAM_W), .BW(TEXD_W), .CW(MUL_CHUNK_W)) u_mul_a (
         .clock(clock), .en(en), .a(den), .b(ta), .p(pa));
      bcuv_mul #(.AW(GRAM_W), .BW(TEXD_W), .CW(MUL_CHUNK_W)) u_mul_b (
         .clock(clock), .en(en), .a(nv), .b(db), .p(pb));
      bcuv_mul #(.AW(GRAM_W), .BW(TEXD_W), .CW(MUL_CHUNK_W)) u_mul_c (
         .clock(clock), .en(en), .a(nw), .b(dc), .p(pc));

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff <= pa + pb + pc;
         end
      end

      bcuv_div u_div (
         .clock(clock), .en(en), .num(num_ff), .den(den_dly_ff[MUL_LAT]),
         .result(res[c]), .degenerate(deg[c]));
   end

   assign rsp_ch.valid      = vld_ff[PIPE_LAT-1];
   assign rsp_ch.out_u      = res[0];
   assign rsp_ch.out_v      = res[1];
   assign rsp_ch.degenerate = deg[0];

   // A degenerate triangle always yields zero coordinates.
   `BCUV_ASSERT_SAME(a_degen_zero, rsp_ch.valid && rsp_ch.degenerate,
      rsp_ch.out_u == '0 && rsp_ch.out_v == '0)
   // Both lanes agree on the degenerate flag.
   `BCUV_ASSERT_SAME(a_degen_lanes, rsp_ch.valid, deg[0] == deg[1])
   // A held pipeline keeps its valid bits.
   `BCUV_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_ff))
   // An item one stage from the end reaches the output on the next advance.
   `BCUV_ASSERT_NEXT(a_reach_out, en && vld_ff[PIPE_LAT-2], rsp_ch.valid)

endmodule

// ===== hdl/bcuv_mul.sv =====
// Two-stage signed multiplier built from registered chunk products.
module bcuv_mul #(
   parameter int AW = 44,
   parameter int BW = 44,
   parameter int CW = 22
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] p
);

   localparam int NA  = (AW + CW - 1) / CW;
   localparam int NB  = (BW + CW - 1) / CW;
   localparam int PW  = AW + BW;
   localparam int PPW = 2 * CW + 2;

   logic signed [NA*CW-1:0] ax;
   logic signed [NB*CW-1:0] bx;
   logic signed [PPW-1:0]   part_ff [NA*NB];
   logic signed [PW-1:0]    sum;
   logic signed [PW-1:0]    p_ff;

   assign ax = (NA*CW)'(a);
   assign bx = (NB*CW)'(b);

   // First stage: one small product per pair of chunks; only the top chunks are signed.
   for (genvar i = 0; i < NA; i++) begin : g_a
      for (genvar j = 0; j < NB; j++) begin : g_b
         logic signed [CW:0] ach;
         logic signed [CW:0] bch;
         if (i == NA - 1) begin : g_atop
            assign ach = {ax[NA*CW-1], ax[i*CW +: CW]};
         end else begin : g_alow
            assign ach = {1'b0, ax[i*CW +: CW]};
         end
         if (j == NB - 1) begin : g_btop
            assign bch = {bx[NB*CW-1], bx[j*CW +: CW]};
         end else begin : g_blow
            assign bch = {1'b0, bx[j*CW +: CW]};
         end
         always_ff @(posedge clock) begin
            if (en) begin
               part_ff[i*NB+j] <= ach * bch;
            end
         end
      end
   end

   // Second stage: add the shifted chunk products.
   always_comb begin
      sum = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum = sum + (PW'(part_ff[i*NB+j]) <<< ((i + j) * CW));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= sum;
      end
   end

   assign p = p_ff;

endmodule

// ===== hdl/bcuv_gram.sv =====
// Edge vectors, dot products, Gram determinant and weight numerators.
module bcuv_gram import bcuv_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  coord_type  point_x,
   input  coord_type  point_y,
   input  coord_type  point_z,
   input  vertex_type vertex_a,
   input  vertex_type vertex_b,
   input  vertex_type vertex_c,
   output gram_type   den,
   output gram_type   nv,
   output gram_type   nw
);

   coord_type                 pt [3];
   logic signed [EDGE_W-1:0]  e0_ff [3];
   logic signed [EDGE_W-1:0]  e1_ff [3];
   logic signed [EDGE_W-1:0]  e2_ff [3];
   logic signed [PROD_W-1:0]  m00_ff [3];
   logic signed [PROD_W-1:0]  m01_ff [3];
   logic signed [PROD_W-1:0]  m11_ff [3];
   logic signed [PROD_W-1:0]  m20_ff [3];
   logic signed [PROD_W-1:0]  m21_ff [3];
   logic signed [DOT_W-1:0]   d00_ff;
   logic signed [DOT_W-1:0]   d01_ff;
   logic signed [DOT_W-1:0]   d11_ff;
   logic signed [DOT_W-1:0]   d20_ff;
   logic signed [DOT_W-1:0]   d21_ff;
   gram_type                  p0011;
   gram_type                  p0101;
   gram_type                  p1120;
   gram_type                  p0121;
   gram_type                  p0021;
   gram_type                  p0120;
   gram_type                  den_ff;
   gram_type                  nv_ff;
   gram_type                  nw_ff;

   assign pt[0] = point_x;
   assign pt[1] = point_y;
   assign pt[2] = point_z;

   // Edge vectors from vertex A.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            e0_ff[k] <= EDGE_W'(coord_type'(vertex_b[k*COORD_W +: COORD_W]))
                      - EDGE_W'(coord_type'(vertex_a[k*COORD_W +: COORD_W]));
            e1_ff[k] <= EDGE_W'(coord_type'(vertex_c[k*COORD_W +: COORD_W]))
                      - EDGE_W'(coord_type'(vertex_a[k*COORD_W +: COORD_W]));
            e2_ff[k] <= EDGE_W'(pt[k])
                      - EDGE_W'(coord_type'(vertex_a[k*COORD_W +: COORD_W]));
         end
      end
   end

   // Per-axis products of the five dot products.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            m00_ff[k] <= e0_ff[k] * e0_ff[k];
            m01_ff[k] <= e0_ff[k] * e1_ff[k];
            m11_ff[k] <= e1_ff[k] * e1_ff[k];
            m20_ff[k] <= e2_ff[k] * e0_ff[k];
            m21_ff[k] <= e2_ff[k] * e1_ff[k];
         end
      end
   end

   // Sums over the three axes.
   always_ff @(posedge clock) begin
      if (en) begin
         d00_ff <= DOT_W'(m00_ff[0]) + DOT_W'(m00_ff[1]) + DOT_W'(m00_ff[2]);
         d01_ff <= DOT_W'(m01_ff[0]) + DOT_W'(m01_ff[1]) + DOT_W'(m01_ff[2]);
         d11_ff <= DOT_W'(m11_ff[0]) + DOT_W'(m11_ff[1]) + DOT_W'(m11_ff[2]);
         d20_ff <= DOT_W'(m20_ff[0]) + DOT_W'(m20_ff[1]) + DOT_W'(m20_ff[2]);
         d21_ff <= DOT_W'(m21_ff[0]) + DOT_W'(m21_ff[1]) + DOT_W'(m21_ff[2]);
      end
   end

   // Wide products of dot products.
   bcuv_mul #(.AW(DOT_W), .BW(DOT_W), .CW(MUL_CHUNK_W)) u_mul_0011 (
      .clock(clock), .en(en), .a(d00_ff), .b(d11_ff), .p(p0011));
   bcuv_mul #(.AW(DOT_W), .BW(DOT_W), .CW(MUL_CHUNK_W)) u_mul_0101 (
      .clock(clock), .en(en), .a(d01_ff), .b(d01_ff), .p(p0101));
   bcuv_mul #(.AW(DOT_W), .BW(DOT_W), .CW(MUL_CHUNK_W)) u_mul_1120 (
      .clock(clock), .en(en), .a(d11_ff), .b(d20_ff), .p(p1120));
   bcuv_mul #(.AW(DOT_W), .BW(DOT_W), .CW(MUL_CHUNK_W)) u_mul_0121 (
      .clock(clock), .en(en), .a(d01_ff), .b(d21_ff), .p(p0121));
   bcuv_mul #(.AW(DOT_W), .BW(DOT_W), .CW(MUL_CHUNK_W)) u_mul_0021 (
      .clock(clock), .en(en), .a(d00_ff), .b(d21_ff), .p(p0021));
   bcuv_mul #(.AW(DOT_W), .BW(DOT_W), .CW(MUL_CHUNK_W)) u_mul_0120 (
      .clock(clock), .en(en), .a(d01_ff), .b(d20_ff), .p(p0120));

   // Determinant and the two weight numerators.
   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= p0011 - p0101;
         nv_ff  <= p1120 - p0121;
         nw_ff  <= p0021 - p0120;
      end
   end

   assign den = den_ff;
   assign nv  = nv_ff;
   assign nw  = nw_ff;

endmodule

// ===== hdl/bcuv_div.sv =====
// Pipelined rounding divide of the weighted sum by the determinant, with saturation.
module bcuv_div import bcuv_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  num_type  num,
   input  gram_type den,
   output out_type  result,
   output logic     degenerate
);

   localparam int RW = NUM_W + 1;
   localparam logic [QUO_W-1:0] Q_POS_LIMIT = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0] Q_NEG_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

   logic signed [RW-1:0] num_ext;
   logic [RW-1:0]        mag1_ff;
   logic [RW-1:0]        dv1_ff;
   logic                 neg1_ff;
   logic                 deg1_ff;
   logic [RW-1:0]        rem2_ff;
   logic [RW-1:0]        dv2_ff;
   logic                 neg2_ff;
   logic                 deg2_ff;
   logic [RW-1:0]        rem_ff [QUO_W+1];
   logic [RW-1:0]        dv_ff  [QUO_W+1];
   logic [QUO_W-1:0]     q_ff   [QUO_W+1];
   logic                 neg_ff [QUO_W+1];
   logic                 sat_ff [QUO_W+1];
   logic                 deg_ff [QUO_W+1];
   logic [QUO_W-1:0]     q_fin;
   out_type              res_in;
   out_type              res_ff;
   logic                 deg_out_ff;

   assign num_ext = RW'(num);

   // Magnitude and sign of the numerator; a determinant of zero or below is degenerate.
   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= num[NUM_W-1];
         mag1_ff <= num[NUM_W-1] ? -num_ext : num_ext;
         dv1_ff  <= RW'(den[GRAM_W-2:0]);
         deg1_ff <= den[GRAM_W-1] || (den == '0);
      end
   end

   // Add half the determinant for round to nearest, ties away from zero.
   always_ff @(posedge clock) begin
      if (en) begin
         rem2_ff <= mag1_ff + (dv1_ff >> 1);
         dv2_ff  <= dv1_ff;
         neg2_ff <= neg1_ff;
         deg2_ff <= deg1_ff;
      end
   end

   // A quotient of 2^QUO_W or more saturates in either direction.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem2_ff;
         dv_ff[0]  <= dv2_ff;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg2_ff;
         sat_ff[0] <= rem2_ff >= (dv2_ff << QUO_W);
         deg_ff[0] <= deg2_ff;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int SH = QUO_W - 1 - k;
      logic [RW-1:0] dsh;
      logic          fits;
      assign dsh  = dv_ff[k] << SH;
      assign fits = rem_ff[k] >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= fits ? rem_ff[k] - dsh : rem_ff[k];
            q_ff[k+1]   <= q_ff[k] | (QUO_W'(fits) << SH);
            dv_ff[k+1]  <= dv_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            sat_ff[k+1] <= sat_ff[k];
            deg_ff[k+1] <= deg_ff[k];
         end
      end
   end

   // Sign, saturation and the degenerate case.
   assign q_fin = q_ff[QUO_W];
   always_comb begin
      priority if (deg_ff[QUO_W]) begin
         res_in = '0;
      end else if (neg_ff[QUO_W]) begin
         res_in = (sat_ff[QUO_W] || q_fin > Q_NEG_LIMIT) ? OUT_MIN : -out_type'(q_fin);
      end else begin
         res_in = (sat_ff[QUO_W] || q_fin > Q_POS_LIMIT) ? OUT_MAX : out_type'(q_fin);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff     <= res_in;
         deg_out_ff <= deg_ff[QUO_W];
      end
   end

   assign result     = res_ff;
   assign degenerate = deg_out_ff;

endmodule

// ===== tb/tb_triangle_barycentric_uv_unit.sv =====
// Self-checking testbench of the barycentric texture-coordinate unit.
module tb_triangle_barycentric_uv_unit;
   import bcuv_pkg::*;

   typedef struct packed {
      coord_type  point_x;
      coord_type  point_y;
      coord_type  point_z;
      vertex_type vertex_a;
      vertex_type vertex_b;
      vertex_type vertex_c;
      tex_type    tex_a;
      tex_type    tex_b;
      tex_type    tex_c;
   } hit_item_type;

   typedef struct packed {
      out_type out_u;
      out_type out_v;
      logic    degenerate;
   } uv_result_type;

   typedef struct packed {
      hit_item_type  item;
      logic          fixed;
      uv_result_type result;
   } stim_row_type;

   localparam coord_type C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam coord_type C_ONE = 20'sd1024;
   localparam int RANDOM_ITEMS = 1400;

   logic clock;
   logic reset;
   logic failed = 1'b0;
   uv_result_type expected_uv[$];

   bcuv_req_if req_ch();
   bcuv_rsp_if rsp_ch();

   triangle_barycentric_uv_unit dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic vertex_type vtx(coord_type x, coord_type y, coord_type z);
      return {z, y, x};
   endfunction

   // Rounds one texture component of the weighted sum, ties away from zero, then saturates.
   function automatic out_type blend_tex(logic signed [127:0] den, logic signed [127:0] nv,
                                         logic signed [127:0] nw, logic [TEX_W-1:0] ta,
                                         logic [TEX_W-1:0] tb, logic [TEX_W-1:0] tc);
      logic signed [127:0] a, b, c, num, mag, q;
      a = {112'd0, ta};
      b = {112'd0, tb};
      c = {112'd0, tc};
      num = den * a + nv * (b - a) + nw * (c - a);
      mag = (num < 0) ? -num : num;
      q = (mag + (den >>> 1)) / den;
      if (num < 0) return (q > 65536) ? OUT_MIN : out_type'(-q);
      return (q > 65535) ? OUT_MAX : out_type'(q);
   endfunction

   // Expected texture coordinate of one hit from its edge dot products.
   function automatic uv_result_type predict_uv(hit_item_type it);
      logic signed [127:0] p[3], a[3], b[3], c[3];
      logic signed [127:0] d00, d01, d11, d20, d21, den, nv, nw;
      uv_result_type r;
      p[0] = it.point_x;
      p[1] = it.point_y;
      p[2] = it.point_z;
      for (int k = 0; k < 3; k++) begin
         a[k] = $signed(it.vertex_a[COORD_W*k +: COORD_W]);
         b[k] = $signed(it.vertex_b[COORD_W*k +: COORD_W]);
         c[k] = $signed(it.vertex_c[COORD_W*k +: COORD_W]);
      end
      d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
      for (int k = 0; k < 3; k++) begin
         d00 += (b[k] - a[k]) * (b[k] - a[k]);
         d01 += (b[k] - a[k]) * (c[k] - a[k]);
         d11 += (c[k] - a[k]) * (c[k] - a[k]);
         d20 += (p[k] - a[k]) * (b[k] - a[k]);
         d21 += (p[k] - a[k]) * (c[k] - a[k]);
      end
      den = d00 * d11 - d01 * d01;
      nv = d11 * d20 - d01 * d21;
      nw = d00 * d21 - d01 * d20;
      r = '0;
      if (den <= 0) begin
         r.degenerate = 1'b1;
      end else begin
         r.out_u = blend_tex(den, nv, nw, it.tex_a[15:0], it.tex_b[15:0], it.tex_c[15:0]);
         r.out_v = blend_tex(den, nv, nw, it.tex_a[31:16], it.tex_b[31:16], it.tex_c[31:16]);
      end
      return r;
   endfunction

   function automatic coord_type rand_coord(int span);
      return coord_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // Random hits: mostly sane triangles with the point near them, plus noise and degenerates.
   function automatic hit_item_type random_hit();
      hit_item_type it;
      int mode, span;
      coord_type k;
      logic [383:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(hit_item_type)-1:0];
      mode = $urandom_range(0, 9);
      span = ($urandom_range(0, 3) == 0) ? 8000 : 500000;
      if (mode <= 5) begin
         it.vertex_a = vtx(rand_coord(span), rand_coord(span), rand_coord(span));
         it.vertex_b = vtx(rand_coord(span), rand_coord(span), rand_coord(span));
         it.vertex_c = vtx(rand_coord(span), rand_coord(span), rand_coord(span));
         // Point as an average of the vertices keeps it near the plane.
         it.point_x = coord_type'((int'($signed(it.vertex_a[19:0]))
                       + int'($signed(it.vertex_b[19:0]))
                       + int'($signed(it.vertex_c[19:0]))) / 3);
         it.point_y = coord_type'((int'($signed(it.vertex_a[39:20]))
                       + int'($signed(it.vertex_b[39:20]))
                       + int'($signed(it.vertex_c[39:20]))) / 3);
         it.point_z = coord_type'((int'($signed(it.vertex_a[59:40]))
                       + int'($signed(it.vertex_b[59:40]))
                       + int'($signed(it.vertex_c[59:40]))) / 3);
         if (mode == 5) it.point_x = it.point_x + rand_coord(2000);
      end else if (mode == 6) begin
         // Degenerate: two vertices coincide or the third lies on the line of the first edge.
         it.vertex_b = vtx(rand_coord(span), rand_coord(span), rand_coord(span));
         if ($urandom_range(0, 1)) begin
            it.vertex_c = it.vertex_b;
         end else begin
            k = coord_type'($urandom_range(0, 3));
            it.vertex_a = '0;
            it.vertex_b = vtx(rand_coord(2000), rand_coord(2000), rand_coord(2000));
            it.vertex_c = vtx($signed(it.vertex_b[19:0]) * k, $signed(it.vertex_b[39:20]) * k,
                              $signed(it.vertex_b[59:40]) * k);
         end
      end
      return it;
   endfunction

   // Directed rows; fixed rows carry a result that follows from the geometry directly.
   function automatic stim_row_type make_row(int idx);
      stim_row_type row;
      row = '0;
      row.item.vertex_a = '0;
      row.item.vertex_b = vtx(C_ONE, '0, '0);
      row.item.vertex_c = vtx('0, C_ONE, '0);
      row.item.tex_a = 32'h1234_7FFF;
      row.item.tex_b = 32'hFFFF_0000;
      row.item.tex_c = 32'h0000_FFFF;
      case (idx)
         0: begin
            // All vertices at the origin give a zero determinant.
            row.item.vertex_b = '0;
            row.item.vertex_c = '0;
            row.fixed = 1'b1;
            row.result = '{out_u: '0, out_v: '0, degenerate: 1'b1};
         end
         1: begin
            // Hit on the first vertex returns its texture coordinate.
            row.fixed = 1'b1;
            row.result = '{out_u: 17'sh07FFF, out_v: 17'sh01234, degenerate: 1'b0};
         end
         2: begin
            row.item.point_x = C_ONE;
            row.fixed = 1'b1;
            row.result = '{out_u: 17'sh00000, out_v: 17'sh0FFFF, degenerate: 1'b0};
         end
         3: begin
            row.item.point_y = C_ONE;
            row.fixed = 1'b1;
            row.result = '{out_u: 17'sh0FFFF, out_v: 17'sh00000, degenerate: 1'b0};
         end
         4: begin
            // Collinear vertices, also degenerate.
            row.item.vertex_c = vtx(C_MAX, '0, '0);
            row.fixed = 1'b1;
            row.result = '{out_u: '0, out_v: '0, degenerate: 1'b1};
         end
         5: begin
            // Far outside the triangle: saturates high.
            row.item.point_x = C_MAX;
            row.item.point_y = C_MAX;
            row.item.tex_a = '0;
            row.item.tex_b = '1;
            row.item.tex_c = '1;
            row.fixed = 1'b1;
            row.result = '{out_u: OUT_MAX, out_v: OUT_MAX, degenerate: 1'b0};
         end
         6: begin
            // Far outside on the other side: saturates low.
            row.item.point_x = C_MIN;
            row.item.point_y = C_MIN;
            row.item.tex_a = '0;
            row.item.tex_b = '1;
            row.item.tex_c = '1;
            row.fixed = 1'b1;
            row.result = '{out_u: OUT_MIN, out_v: OUT_MIN, degenerate: 1'b0};
         end
         7: begin
            row.item.vertex_a = vtx(C_MIN, C_MIN, C_MIN);
            row.item.vertex_b = vtx(C_MAX, C_MIN, C_MAX);
            row.item.vertex_c = vtx(C_MIN, C_MAX, C_MAX);
            row.item.point_x = C_MAX;
            row.item.point_y = C_MAX;
            row.item.point_z = C_MAX;
         end
         8: begin
            row.item.vertex_a = vtx(C_MAX, C_MAX, C_MAX);
            row.item.vertex_b = vtx(C_MIN, C_MAX, C_MIN);
            row.item.vertex_c = vtx(C_MAX, C_MIN, C_MIN);
            row.item.point_x = '0;
            row.item.point_y = C_MIN;
            row.item.point_z = 20'sd5;
            row.item.tex_a = '1;
         end
         9: begin
            // Above the midpoint of the far edge, ties in the rounding.
            row.item.point_x = 20'sd512;
            row.item.point_y = 20'sd512;
            row.item.point_z = C_MAX;
            row.item.tex_a = 32'h0001_0001;
            row.item.tex_b = 32'h0000_0000;
            row.item.tex_c = 32'h0001_0000;
         end
         default: row.item = random_hit();
      endcase
      if (!row.fixed) row.result = predict_uv(row.item);
      return row;
   endfunction

   // Response stalls: a pattern that shifts between ready, sparse and busy phases.
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 200) % 4)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= (stall_phase % 7) < 4;
      endcase
   end

   // Compare each result with the oldest outstanding prediction.
   always @(posedge clock) begin
      uv_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_uv.size() == 0) begin
            $display("%0t: unexpected result u=%h v=%h degenerate=%b", $time,
                     rsp_ch.out_u, rsp_ch.out_v, rsp_ch.degenerate);
            failed <= 1'b1;
         end else begin
            want = expected_uv.pop_front();
            if (rsp_ch.out_u !== want.out_u) begin
               $display("%0t: out_u expected %h actual %h", $time, want.out_u, rsp_ch.out_u);
               failed <= 1'b1;
            end
            if (rsp_ch.out_v !== want.out_v) begin
               $display("%0t: out_v expected %h actual %h", $time, want.out_v, rsp_ch.out_v);
               failed <= 1'b1;
            end
            if (rsp_ch.degenerate !== want.degenerate) begin
               $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                        rsp_ch.degenerate);
               failed <= 1'b1;
            end
         end
      end
   end

   int burst_left;

   // Present one item, holding valid high until it is taken, then push its prediction.
   task automatic send_hit(hit_item_type it, uv_result_type want);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 2) == 0) ? 40 : $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      {req_ch.point_x, req_ch.point_y, req_ch.point_z, req_ch.vertex_a, req_ch.vertex_b,
       req_ch.vertex_c, req_ch.tex_a, req_ch.tex_b, req_ch.tex_c} <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_uv.push_back(want);
   endtask

   initial begin
      stim_row_type row;
      hit_item_type it;
      int waited;
      burst_left = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      {req_ch.point_x, req_ch.point_y, req_ch.point_z, req_ch.vertex_a, req_ch.vertex_b,
       req_ch.vertex_c, req_ch.tex_a, req_ch.tex_b, req_ch.tex_c} <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      for (int i = 0; i < 14; i++) begin
         row = make_row(i);
         send_hit(row.item, row.result);
      end

      // Random part, with one full drain in the middle.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            req_ch.valid <= 1'b0;
            burst_left = 0;
            while (expected_uv.size() != 0) @(posedge clock);
         end
         it = random_hit();
         send_hit(it, predict_uv(it));
      end
      req_ch.valid <= 1'b0;

      // Drain, then allow the pipeline latency for stray results.
      waited = 0;
      while (expected_uv.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (!failed && expected_uv.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
